// ===== hdl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN_BYTES     = 8;
    localparam int MAX_REPLACEMENT_BYTES = 8;

    // Largest number of results that one input byte can cause.
    localparam int MAX_RESULTS = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                                 MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W  = 4;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef logic [7:0] t_byte;

    // Pattern length as used by the matcher: zero counts as one, and
    // anything above the window size saturates.
    function automatic logic [LEN_W-1:0] f_active_plen(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_PATTERN_BYTES)) begin
            res = LEN_W'(MAX_PATTERN_BYTES);
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] f_active_rlen(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
            res = LEN_W'(MAX_REPLACEMENT_BYTES);
        end
        return res;
    endfunction

endpackage

// ===== hdl/stream_find_and_replace_unit.sv =====
`timescale 1ns / 1ps

// Streaming find-and-replace. Text enters one byte per transfer, with
// i_end_of_string set on the final byte of each string, and every leftmost,
// non-overlapping occurrence of the configured pattern (1 to 8 bytes) is
// replaced by the configured replacement (0 to 8 bytes). A lookahead window
// holds the bytes that could still begin a match; once it holds
// pattern-length bytes it either matches (the replacement goes out and the
// window empties) or releases its oldest byte. At the end of a string the
// waiting bytes are flushed, and if nothing at all goes out for the final
// byte, a marker result with o_byte_valid low carries o_last_of_string.
// Rate: a byte that causes at most one result lets the next byte in once the
// receiver takes that result. A byte that causes N results (a match with an
// N-byte replacement, or an end-of-string flush of N bytes) loads them all
// into the output burst register and stalls the input until the last is
// taken; the burst register drains one result per cycle while i_stall is
// low and is the only source of o_stall. Configuration is written through
// a plain write port, by the user only while the block is idle; the block
// does not enforce this. Writing the pattern length empties the window.
module stream_find_and_replace_unit
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_string,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_string
);

    // Configuration registers.
    logic [63:0]      r_pattern_bytes;
    logic [LEN_W-1:0] r_pattern_length;
    logic [63:0]      r_replacement_bytes;
    logic [LEN_W-1:0] r_replacement_length;

    // Lookahead window, oldest byte in entry 0.
    t_byte             r_win [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] r_fill;

    // Output burst register: a short queue that shifts toward entry 0.
    t_byte            r_ob [MAX_RESULTS];
    logic [CNT_W-1:0] r_ocnt;
    logic             r_omarker;
    logic             r_olast;

    t_byte             n_win [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] n_fill;
    t_byte             n_ob [MAX_RESULTS];
    logic [CNT_W-1:0]  n_ocnt;
    logic              n_omarker;
    logic              n_olast;

    logic              in_xfer;
    logic              out_xfer;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_inc;
    logic              full;
    logic              match;
    t_byte             wnew [MAX_PATTERN_BYTES];
    logic [CNT_W-1:0]  emit_cnt;
    logic              emit_repl;

    assign plen     = f_active_plen(r_pattern_length);
    assign rlen     = f_active_rlen(r_replacement_length);
    assign fill_inc = LEN_W'(r_fill) + LEN_W'(1);
    assign full     = (fill_inc == plen);

    // The output side may accept only when the burst register is empty or
    // hands over its last result in this cycle.
    assign o_stall  = (r_ocnt > CNT_W'(1)) || ((r_ocnt == CNT_W'(1)) && i_stall);
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_ocnt != '0);
    assign out_xfer = o_valid && !i_stall;

    assign o_out_byte       = r_ob[0];
    assign o_byte_valid     = !r_omarker;
    assign o_last_of_string = r_olast && (r_ocnt == CNT_W'(1));

    // Window with the new byte written at the fill position, and the
    // comparison against the pattern over the active length.
    always_comb begin
        match = full;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            wnew[k] = (FILL_W'(k) == r_fill) ? i_text_byte : r_win[k];
            if ((LEN_W'(k) < plen) && (wnew[k] != r_pattern_bytes[8*k +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // Results for this byte are either the replacement or a run of window
    // bytes from the oldest one on.
    always_comb begin
        emit_repl = 1'b0;
        emit_cnt  = '0;
        n_fill    = r_fill;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            n_win[k] = wnew[k];
        end
        priority if (match) begin
            emit_repl = 1'b1;
            emit_cnt  = CNT_W'(rlen);
            n_fill    = '0;
        end else if (full) begin
            if (i_end_of_string) begin
                emit_cnt = CNT_W'(plen);
            end else begin
                emit_cnt = CNT_W'(1);
            end
            for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
                n_win[k] = wnew[k+1];
            end
            n_fill = r_fill;
        end else begin
            if (i_end_of_string) begin
                emit_cnt = CNT_W'(fill_inc);
            end
            n_fill = FILL_W'(fill_inc);
        end
        if (i_end_of_string) begin
            n_fill = '0;
        end
    end

    // Burst register: load on an input transfer that produces results,
    // otherwise shift out one result per output transfer.
    always_comb begin
        n_ocnt    = r_ocnt;
        n_omarker = r_omarker;
        n_olast   = r_olast;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_ob[k] = r_ob[k];
        end
        if (out_xfer) begin
            n_ocnt = r_ocnt - CNT_W'(1);
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                n_ob[k] = r_ob[k+1];
            end
        end
        if (in_xfer && ((emit_cnt != '0) || i_end_of_string)) begin
            n_olast = i_end_of_string;
            if (emit_cnt == '0) begin
                // Nothing left to send at the end of a string: send a marker.
                n_ocnt    = CNT_W'(1);
                n_omarker = 1'b1;
                n_ob[0]   = '0;
            end else begin
                n_ocnt    = emit_cnt;
                n_omarker = 1'b0;
                for (int k = 0; k < MAX_RESULTS; k++) begin
                    if (emit_repl) begin
                        n_ob[k] = (k < MAX_REPLACEMENT_BYTES) ?
                                  r_replacement_bytes[8*(k % MAX_REPLACEMENT_BYTES) +: 8] :
                                  t_byte'(0);
                    end else begin
                        n_ob[k] = (k < MAX_PATTERN_BYTES) ?
                                  wnew[k % MAX_PATTERN_BYTES] : t_byte'(0);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= LEN_W'(1);
            r_replacement_bytes  <= '0;
            r_replacement_length <= '0;
            r_fill               <= '0;
            r_ocnt               <= '0;
            r_omarker            <= 1'b0;
            r_olast              <= 1'b0;
        end else begin
            r_ocnt    <= n_ocnt;
            r_omarker <= n_omarker;
            r_olast   <= n_olast;
            // A pattern length write empties the window.
            if (i_cfg_we && (i_cfg_index == REG_PATTERN_LENGTH)) begin
                r_fill <= '0;
            end else if (in_xfer) begin
                r_fill <= n_fill;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PATTERN_BYTES: begin
                        r_pattern_bytes <= i_cfg_data;
                    end
                    REG_PATTERN_LENGTH: begin
                        r_pattern_length <= i_cfg_data[LEN_W-1:0];
                    end
                    REG_REPLACEMENT_BYTES: begin
                        r_replacement_bytes <= i_cfg_data;
                    end
                    REG_REPLACEMENT_LENGTH: begin
                        r_replacement_length <= i_cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                r_win[k] <= n_win[k];
            end
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            r_ob[k] <= n_ob[k];
        end
    end

    // The window never holds a full pattern between transfers.
    a_fill_below_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_fill) < plen))
        else $error("lookahead window fill reached the pattern length");

    // The burst register never holds more results than one byte can cause.
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt <= CNT_W'(MAX_RESULTS)))
        else $error("output burst count out of range");

    // A new byte is taken only when the burst register is emptying.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ((r_ocnt == '0) || ((r_ocnt == CNT_W'(1)) && out_xfer)))
        else $error("input transfer would overwrite pending results");

    // A marker result always closes a string.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last_of_string)
        else $error("marker result without end of string");

endmodule

// ===== dv/find_replace_checker.sv =====
`timescale 1ns / 1ps

module find_replace_checker
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_byte       i_text_byte,
    input  logic        i_end_of_string,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_byte       i_out_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_of_string,
    output int          o_failures,
    output int          o_pending
);

    typedef struct packed {
        t_byte out_byte;
        logic  byte_valid;
        logic  last_of_string;
    } t_rewrite;

    logic [63:0] pattern_word;
    logic [3:0]  pattern_len_reg;
    logic [63:0] replacement_word;
    logic [3:0]  replacement_len_reg;

    t_byte    window [MAX_PATTERN_BYTES];
    int       window_fill;
    t_rewrite rewrites_due [$];
    int       failures = 0;
    int       pending  = 0;

    assign o_failures = failures;
    assign o_pending  = pending;

    // Works out what one accepted text byte releases and queues it in order.
    task automatic rewrite_byte(input t_byte b, input logic eos);
        t_rewrite step_out [2*MAX_RESULTS];
        int       n;
        int       k;
        int       plen;
        int       rlen;
        logic     hit;
        n    = 0;
        plen = int'(pattern_len_reg);
        if (plen == 0) begin
            plen = 1;
        end else if (plen > MAX_PATTERN_BYTES) begin
            plen = MAX_PATTERN_BYTES;
        end
        rlen = int'(replacement_len_reg);
        if (rlen > MAX_REPLACEMENT_BYTES) begin
            rlen = MAX_REPLACEMENT_BYTES;
        end

        window[window_fill] = b;
        window_fill++;

        if (window_fill == plen) begin
            hit = 1'b1;
            for (k = 0; k < plen; k++) begin
                if (window[k] != pattern_word[8*k +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (k = 0; k < rlen; k++) begin
                    step_out[n] = '{replacement_word[8*k +: 8], 1'b1, 1'b0};
                    n++;
                end
                window_fill = 0;
            end else begin
                step_out[n] = '{window[0], 1'b1, 1'b0};
                n++;
                for (k = 1; k < plen; k++) begin
                    window[k-1] = window[k];
                end
                window_fill--;
            end
        end

        if (eos) begin
            for (k = 0; k < window_fill; k++) begin
                step_out[n] = '{window[k], 1'b1, 1'b0};
                n++;
            end
            window_fill = 0;
            // Nothing left to carry the end of the string, so a marker goes out.
            if (n == 0) begin
                step_out[n] = '{8'h00, 1'b0, 1'b0};
                n++;
            end
            step_out[n-1].last_of_string = 1'b1;
        end

        for (k = 0; k < n; k++) begin
            rewrites_due = {rewrites_due, step_out[k]};
        end
    endtask

    task automatic check_result();
        t_rewrite due;
        if (rewrites_due.size() == 0) begin
            $error("unexpected result: out_byte %02h byte_valid %0b last_of_string %0b",
                   i_out_byte, i_byte_valid, i_last_of_string);
            failures++;
        end else begin
            due = rewrites_due.pop_front();
            if (i_out_byte !== due.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", due.out_byte, i_out_byte);
                failures++;
            end
            if (i_byte_valid !== due.byte_valid) begin
                $error("byte_valid: expected %0b, actual %0b", due.byte_valid, i_byte_valid);
                failures++;
            end
            if (i_last_of_string !== due.last_of_string) begin
                $error("last_of_string: expected %0b, actual %0b",
                       due.last_of_string, i_last_of_string);
                failures++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pattern_word        = '0;
            pattern_len_reg     = 4'd1;
            replacement_word    = '0;
            replacement_len_reg = 4'd0;
            window_fill         = 0;
            foreach (window[k]) begin
                window[k] = '0;
            end
            rewrites_due.delete();
        end else begin
            // Results leave from a register, so a result seen at this edge was
            // caused by an earlier byte and is checked before the new one.
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_BYTES: begin
                        pattern_word = i_cfg_data;
                    end
                    REG_PATTERN_LENGTH: begin
                        pattern_len_reg = i_cfg_data[3:0];
                        window_fill     = 0;
                    end
                    REG_REPLACEMENT_BYTES: begin
                        replacement_word = i_cfg_data;
                    end
                    REG_REPLACEMENT_LENGTH: begin
                        replacement_len_reg = i_cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                rewrite_byte(i_text_byte, i_end_of_string);
            end
        end
        pending = rewrites_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sfr_pkg::*;

    // Roughly how many random text bytes follow the directed part.
    localparam int RANDOM_ITEMS = 330;
    // Cycles allowed after the last expected result before the block is
    // considered idle; the longest output burst is eight results.
    localparam int DRAIN_CYCLES = 16;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 80;
    // Cycles without any transfer or register write before the run is
    // declared hung. The slowest legal stretch is the long hold-off plus a
    // drain, far below this.
    localparam int QUIET_LIMIT  = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    t_byte       i_text_byte;
    logic        i_end_of_string;
    logic        o_valid;
    logic        i_stall;
    t_byte       o_out_byte;
    logic        o_byte_valid;
    logic        o_last_of_string;

    int          failures;
    int          pending;
    int          quiet_cycles = 0;
    int          random_items = 0;

    // Random gaps on both sides are on until the closing stretch of the run.
    logic        idling_on    = 1'b1;
    // Raised once to make the receiver hold off for HOLD_CYCLES.
    logic        hold_request = 1'b0;
    // Set by the receiver once the long hold-off has been served.
    logic        hold_done    = 1'b0;

    // Stimulus-side view of the current configuration, used only to shape
    // text so that it hits the pattern often.
    logic [63:0] pattern_word;
    int          pattern_active;

    stream_find_and_replace_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_text_byte      (i_text_byte),
        .i_end_of_string  (i_end_of_string),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last_of_string (o_last_of_string)
    );

    find_replace_checker rewrite_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_text_byte      (i_text_byte),
        .i_end_of_string  (i_end_of_string),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_byte_valid     (o_byte_valid),
        .i_last_of_string (o_last_of_string),
        .o_failures       (failures),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side. It stalls in short random bursts while idling is on,
    // and once per run it holds off for a long stretch so that the block's
    // output register fills and the stall reaches back to the input.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Hang detection: any transfer on either channel or any register write
    // counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // One register write; the write enable is high for exactly one edge.
    task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Offers the bytes one transfer at a time. Valid stays high from one byte
    // to the next unless a random gap is inserted, and each byte is held
    // until the edge at which the block takes it.
    task automatic send_text(input t_byte text [$], input logic end_string);
        int k;
        for (k = 0; k < text.size(); k++) begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_valid         <= 1'b1;
            i_text_byte     <= text[k];
            i_end_of_string <= end_string && (k == text.size() - 1);
            do @(posedge i_clk); while (o_stall);
        end
    endtask

    // Brings the block to rest before a register write or the end of the
    // run. A byte that only fills the window produces nothing, so after the
    // last expected result a further drain wait lets the burst register
    // empty.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Picks a new configuration for one phase of the random part. Lengths
    // include zero and values above the window size, which the block clamps,
    // and the upper bits of the length writes carry noise that must be
    // ignored.
    task automatic configure_random();
        logic [3:0]  plen_code;
        logic [3:0]  rlen_code;
        logic [63:0] word;
        int          k;
        case ($urandom_range(0, 7))
            0:       plen_code = 4'd0;
            1:       plen_code = 4'd15;
            2:       plen_code = 4'($urandom_range(9, 14));
            3:       plen_code = 4'd8;
            default: plen_code = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0:       rlen_code = 4'd0;
            1:       rlen_code = 4'd15;
            2:       rlen_code = 4'($urandom_range(9, 14));
            3:       rlen_code = 4'd8;
            default: rlen_code = 4'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 3))
            0: pattern_word = '0;
            1: pattern_word = '1;
            2: begin
                // A three-letter alphabet makes near misses and repeats common.
                for (k = 0; k < 8; k++) begin
                    pattern_word[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
                end
            end
            default: pattern_word = {$urandom, $urandom};
        endcase
        pattern_active = (plen_code == 4'd0) ? 1 :
                         (plen_code > 4'd8) ? 8 : int'(plen_code);

        write_reg(REG_PATTERN_BYTES, pattern_word);
        word      = {$urandom, $urandom};
        word[3:0] = plen_code;
        write_reg(REG_PATTERN_LENGTH, word);
        write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        word      = {$urandom, $urandom};
        word[3:0] = rlen_code;
        write_reg(REG_REPLACEMENT_LENGTH, word);
    endtask

    // Builds a string mostly from whole and partial copies of the pattern
    // and from bytes of the pattern, with some arbitrary bytes mixed in.
    task automatic send_random_string(input logic end_string);
        t_byte text [$];
        int    k;
        int    cut;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    for (k = 0; k < pattern_active; k++) begin
                        text = {text, t_byte'(pattern_word[8*k +: 8])};
                    end
                end
                2: begin
                    cut = $urandom_range(1, pattern_active);
                    for (k = 0; k < cut; k++) begin
                        text = {text, t_byte'(pattern_word[8*k +: 8])};
                    end
                end
                3: begin
                    k = $urandom_range(0, pattern_active - 1);
                    text = {text, t_byte'(pattern_word[8*k +: 8])};
                end
                4: begin
                    text = {text, t_byte'($urandom_range(0, 255))};
                end
                default: begin
                    repeat ($urandom_range(1, 3)) text = {text, t_byte'($urandom)};
                end
            endcase
        end
        send_text(text, end_string);
        random_items += text.size();
    endtask

    initial begin
        t_byte text [$];
        int    phase;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_PATTERN_BYTES;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_text_byte     = '0;
        i_end_of_string = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a one-byte pattern of zero and an empty
        // replacement, so every zero byte is deleted. A string made of one
        // deleted byte, and one whose last byte is deleted, each end with a
        // marker result.
        text = '{8'h00};
        send_text(text, 1'b1);
        text = '{8'hFF};
        send_text(text, 1'b1);
        text = '{8'h00, 8'h80, 8'h00};
        send_text(text, 1'b1);

        // Two-byte pattern with a full eight-byte replacement; the doubled
        // first letter checks that a failed window releases only one byte.
        settle();
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
        text = '{8'h78, 8'h61, 8'h61, 8'h62, 8'h79, 8'h61, 8'h62};
        send_text(text, 1'b1);

        // Oversized lengths clamp to eight: an all-ones pattern of eight
        // bytes replaced by eight zero bytes, matched by the final byte.
        settle();
        write_reg(REG_PATTERN_BYTES, '1);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_REPLACEMENT_BYTES, '0);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
        text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_text(text, 1'b1);

        // Rewriting the pattern length, even to the same active length, drops the
        // bytes waiting in the window.
        text = '{8'h11, 8'h22, 8'h33};
        send_text(text, 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd8);
        text = '{8'h44};
        send_text(text, 1'b1);

        // A pattern length of zero behaves as one.
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_00A5);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
        text = '{8'hFF, 8'h00};
        send_text(text, 1'b1);

        // Random phases, each under its own configuration. The first phase
        // opens with the long receiver hold-off, and the closing stretch
        // runs with no gaps on either side.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            configure_random();
            if (phase == 0) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            if (random_items >= RANDOM_ITEMS - 70) begin
                idling_on = 1'b0;
            end
            repeat ($urandom_range(3, 8)) send_random_string(1'b1);
            // Sometimes a string is left open; the next length write drops it.
            if ($urandom_range(0, 2) == 0) begin
                send_random_string(1'b0);
            end
            phase++;
        end

        settle();
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
